/* sv/qas_pkg.sv */
// Package for the quoted argument splitter: result kinds, character codes,
// the result record and parser state types. No dependencies.
package qas_pkg;

   localparam int unsigned KindWidth = 2;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CountWidth = 8;
   localparam logic [CountWidth-1:0] MaxArgsReset = 8'd255;

   // Result kinds
   localparam logic [KindWidth-1:0] KIND_BYTE = 2'd0;
   localparam logic [KindWidth-1:0] KIND_END = 2'd1;
   localparam logic [KindWidth-1:0] KIND_DONE = 2'd2;
   localparam logic [KindWidth-1:0] KIND_QUOTE_ERR = 2'd3;

   // Special characters
   localparam logic [ByteWidth-1:0] CHAR_DQUOTE = 8'h22;
   localparam logic [ByteWidth-1:0] CHAR_SQUOTE = 8'h27;
   localparam logic [ByteWidth-1:0] CHAR_BSLASH = 8'h5C;
   localparam logic [ByteWidth-1:0] CHAR_SPACE = 8'h20;
   localparam logic [ByteWidth-1:0] CHAR_TAB = 8'h09;
   localparam logic [ByteWidth-1:0] CHAR_CR = 8'h0D;

   // Result queue geometry
   localparam int unsigned QueueDepth = 3;
   localparam int unsigned QueuePtrWidth = 2;
   localparam int unsigned QueueCntWidth = 2;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic [ByteWidth-1:0] out_byte;
      logic [CountWidth-1:0] arg_index;
      logic [CountWidth-1:0] arg_count;
      logic last;
   } result_type;

   // Up to two results caused by one item
   typedef struct packed {
      logic push_first;
      logic push_second;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic in_single_quote;
      logic in_double_quote;
      logic escape_pending;
      logic at_boundary;
      logic arg_has_bytes;
      logic [CountWidth-1:0] args_done;
   } parse_state_type;

   function automatic logic is_space(input logic [ByteWidth-1:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic [QueuePtrWidth-1:0] ptr_next(input logic [QueuePtrWidth-1:0] p);
      logic [QueuePtrWidth-1:0] r;
      if (p == QueuePtrWidth'(QueueDepth - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

/* sv/qas_parse.sv */
// Parser for the quoted argument splitter: quote/escape state, argument
// counter, max_args register and per-item result generation. Uses qas_pkg.
module qas_parse
   import qas_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic accept,
   input logic [ByteWidth-1:0] cmd_byte,
   input logic end_of_string,
   input logic cfg_write,
   input logic [CountWidth-1:0] cfg_max_args,
   output push_type push
);

   parse_state_type state_ff, state_in;
   logic [CountWidth-1:0] max_args_ff;
   push_type push_c;
   parse_state_type reset_state;
   logic [CountWidth-1:0] done_inc;
   logic ws;
   result_type lit;

   assign reset_state = '{in_single_quote: 1'b0, in_double_quote: 1'b0,
                          escape_pending: 1'b0, at_boundary: 1'b1,
                          arg_has_bytes: 1'b0, args_done: '0};
   assign done_inc = state_ff.args_done + 1'b1;
   assign ws = is_space(cmd_byte);
   assign lit = '{kind: KIND_BYTE, out_byte: cmd_byte, arg_index: state_ff.args_done,
                  arg_count: '0, last: 1'b1};

   // Next state and results for the item on the inputs
   always_comb begin
      state_in = state_ff;
      push_c = '0;
      if (end_of_string) begin
         state_in = reset_state;
         if (state_ff.in_single_quote || state_ff.in_double_quote) begin
            push_c.push_first = 1'b1;
            push_c.first = '{kind: KIND_QUOTE_ERR, out_byte: '0, arg_index: '0,
                             arg_count: '0, last: 1'b1};
         end else if (state_ff.arg_has_bytes && (state_ff.args_done < max_args_ff)) begin
            push_c.push_first = 1'b1;
            push_c.first = '{kind: KIND_END, out_byte: '0, arg_index: state_ff.args_done,
                             arg_count: '0, last: 1'b0};
            push_c.push_second = 1'b1;
            push_c.second = '{kind: KIND_DONE, out_byte: '0, arg_index: '0,
                              arg_count: done_inc, last: 1'b1};
         end else begin
            push_c.push_first = 1'b1;
            push_c.first = '{kind: KIND_DONE, out_byte: '0, arg_index: '0,
                             arg_count: state_ff.args_done, last: 1'b1};
         end
      end else if ((state_ff.args_done < max_args_ff) &&
                   !(state_ff.at_boundary && ws)) begin
         state_in.at_boundary = 1'b0;
         push_c.first = lit;
         if (state_ff.escape_pending) begin
            state_in.escape_pending = 1'b0;
            state_in.arg_has_bytes = 1'b1;
            push_c.push_first = 1'b1;
         end else if (cmd_byte == CHAR_BSLASH) begin
            if (state_ff.in_single_quote) begin
               state_in.arg_has_bytes = 1'b1;
               push_c.push_first = 1'b1;
            end else begin
               state_in.escape_pending = 1'b1;
            end
         end else if (cmd_byte == CHAR_DQUOTE) begin
            if (state_ff.in_single_quote) begin
               state_in.arg_has_bytes = 1'b1;
               push_c.push_first = 1'b1;
            end else begin
               state_in.in_double_quote = !state_ff.in_double_quote;
            end
         end else if (cmd_byte == CHAR_SQUOTE) begin
            if (state_ff.in_double_quote) begin
               state_in.arg_has_bytes = 1'b1;
               push_c.push_first = 1'b1;
            end else begin
               state_in.in_single_quote = !state_ff.in_single_quote;
            end
         end else if (ws && !state_ff.in_single_quote && !state_ff.in_double_quote) begin
            // unquoted whitespace closes the argument, even an empty one
            push_c.push_first = 1'b1;
            push_c.first = '{kind: KIND_END, out_byte: '0, arg_index: state_ff.args_done,
                             arg_count: '0, last: 1'b1};
            state_in.args_done = done_inc;
            state_in.at_boundary = 1'b1;
            state_in.arg_has_bytes = 1'b0;
         end else begin
            state_in.arg_has_bytes = 1'b1;
            push_c.push_first = 1'b1;
         end
      end
   end

   // Parser state and configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= reset_state;
         max_args_ff <= MaxArgsReset;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (cfg_write) begin
            max_args_ff <= cfg_max_args;
         end
      end
   end

   assign push.push_first = push_c.push_first & accept;
   assign push.push_second = push_c.push_second & accept;
   assign push.first = push_c.first;
   assign push.second = push_c.second;

endmodule

/* sv/qas_result_queue.sv */
// Three-entry result queue for the quoted argument splitter; takes up to two
// results per cycle and hands out one per cycle while out_ready is high. Uses qas_pkg.
module qas_result_queue
   import qas_pkg::*;
(
   input logic clock,
   input logic reset,
   input push_type push,
   output logic room,
   output logic out_valid,
   input logic out_ready,
   output result_type out_item
);

   result_type entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;
   logic [QueuePtrWidth-1:0] wr_ptr_second;
   logic pop;
   logic [QueueCntWidth-1:0] n_push;

   assign pop = out_valid && out_ready;
   assign n_push = {1'b0, push.push_first} + {1'b0, push.push_second};
   assign wr_ptr_second = ptr_next(wr_ptr_ff);

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.push_second) begin
         wr_ptr_in = ptr_next(wr_ptr_second);
      end else if (push.push_first) begin
         wr_ptr_in = wr_ptr_second;
      end
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff + n_push - {{(QueueCntWidth-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Result storage, no reset needed
   always_ff @(posedge clock) begin
      if (push.push_first) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.push_second) begin
         entry_ff[wr_ptr_second] <= push.second;
      end
   end

   // Room for the worst case of two results
   assign room = (count_ff <= QueueCntWidth'(QueueDepth - 2));
   assign out_valid = (count_ff != '0);
   assign out_item = entry_ff[rd_ptr_ff];

endmodule

/* sv/quoted_argument_splitter_unit.sv */
// Top level of the quoted argument splitter: parser plus result queue.
// Depends on qas_pkg, qas_parse and qas_result_queue.
//
// Usage:
//   req_*  : one command byte per item (req_cmd_byte), or an end-of-string
//            marker (req_end_of_string = 1), valid/ready handshake.
//   rsp_*  : result items: argument byte, argument end, done with count, or
//            unterminated-quote error; rsp_last flags the final result of
//            each input item. valid/ready handshake.
//   csr_*  : write of max_args, always ready; write only while idle.
// A result is registered in the result queue when its item is accepted and is shown on rsp_* from there.
// Throughput: one input item per cycle while results drain one per cycle.
// An end-of-string item that closes an argument gives two results;
// the three-entry result queue holds both.
// An item is taken only when the queue has room for two results, so a
// stalled receiver holds req_ready low once two or three results wait.
// Reset clears the parser, empties the queue and sets max_args to 255.
module quoted_argument_splitter_unit
   import qas_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [ByteWidth-1:0] req_cmd_byte,
   input logic req_end_of_string,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [KindWidth-1:0] rsp_kind,
   output logic [ByteWidth-1:0] rsp_out_byte,
   output logic [CountWidth-1:0] rsp_arg_index,
   output logic [CountWidth-1:0] rsp_arg_count,
   output logic rsp_last,
   input logic csr_valid,
   output logic csr_ready,
   input logic [CountWidth-1:0] csr_max_args
);

   push_type push;
   result_type out_item;
   logic room;
   logic accept;

   assign req_ready = room;
   assign accept = req_valid && room;
   assign csr_ready = 1'b1;

   qas_parse u_parse (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .cmd_byte(req_cmd_byte),
      .end_of_string(req_end_of_string),
      .cfg_write(csr_valid),
      .cfg_max_args(csr_max_args),
      .push(push)
   );

   qas_result_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .room(room),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_item(out_item)
   );

   assign rsp_kind = out_item.kind;
   assign rsp_out_byte = out_item.out_byte;
   assign rsp_arg_index = out_item.arg_index;
   assign rsp_arg_count = out_item.arg_count;
   assign rsp_last = out_item.last;

endmodule

/* tb/quoted_argument_splitter_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for quoted_argument_splitter_unit: feeds command bytes and
// end-of-string items, predicts the argument stream and checks every result item.
// Depends on qas_pkg and the quoted_argument_splitter_unit RTL.
module quoted_argument_splitter_unit_tb;
   import qas_pkg::*;

   typedef logic [ByteWidth-1:0] char_type;
   typedef logic [CountWidth-1:0] count_type;

   localparam int CycleLimit = 400000;
   localparam int NumPhases = 8;
   localparam int PhaseQuota = 80;

   // one row of the directed part; typed rows carry their single result
   typedef struct packed {
      char_type cmd;
      logic eos;
      logic typed;
      result_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   char_type req_cmd_byte = '0;
   logic req_end_of_string = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [KindWidth-1:0] rsp_kind;
   char_type rsp_out_byte;
   count_type rsp_arg_index;
   count_type rsp_arg_count;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   count_type csr_max_args = '0;

   // splitter state tracked by the predictor
   logic sq_open;
   logic dq_open;
   logic esc_armed;
   logic skipping_ws;
   logic arg_started;
   count_type args_closed;
   count_type arg_limit;

   result_type expected_results[$];
   char_type cmd_bytes[$];
   dir_row_type directed_rows[$];
   int fault_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int counted_items = 0;
   logic sender_gaps_on = 1'b1;
   logic [15:0] ready_pattern = 16'hFFFF;
   int ready_tick = 0;

   quoted_argument_splitter_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd_byte(req_cmd_byte),
      .req_end_of_string(req_end_of_string),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_out_byte(rsp_out_byte),
      .rsp_arg_index(rsp_arg_index),
      .rsp_arg_count(rsp_arg_count),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_max_args(csr_max_args)
   );

   always #2 clock = ~clock;

   function automatic result_type mk_result(input logic [KindWidth-1:0] kind,
                                            input char_type b, input count_type idx,
                                            input count_type cnt, input logic last);
      result_type r;
      r.kind = kind;
      r.out_byte = b;
      r.arg_index = idx;
      r.arg_count = cnt;
      r.last = last;
      return r;
   endfunction

   function automatic logic is_blank(input char_type c);
      return c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
   endfunction

   function automatic void clear_split_state();
      sq_open = 1'b0;
      dq_open = 1'b0;
      esc_armed = 1'b0;
      skipping_ws = 1'b1;
      arg_started = 1'b0;
      args_closed = '0;
   endfunction

   // literal byte appended to the open argument
   function automatic result_type byte_result(input char_type c);
      arg_started = 1'b1;
      return mk_result(KIND_BYTE, c, args_closed, '0, 1'b1);
   endfunction

   // Predict the results of one item and advance the tracked state.
   function automatic int split_step(input char_type c, input logic eos,
                                     output result_type r_a, output result_type r_b);
      r_a = '0;
      r_b = '0;
      if (eos) begin
         if (sq_open || dq_open) begin
            r_a = mk_result(KIND_QUOTE_ERR, '0, '0, '0, 1'b1);
            clear_split_state();
            return 1;
         end
         // an open argument is closed only if it holds bytes and fits the limit
         if (arg_started && args_closed < arg_limit) begin
            r_a = mk_result(KIND_END, '0, args_closed, '0, 1'b0);
            r_b = mk_result(KIND_DONE, '0, '0, args_closed + 1'b1, 1'b1);
            clear_split_state();
            return 2;
         end
         r_a = mk_result(KIND_DONE, '0, '0, args_closed, 1'b1);
         clear_split_state();
         return 1;
      end
      if (args_closed >= arg_limit) return 0;
      if (skipping_ws && is_blank(c)) return 0;
      skipping_ws = 1'b0;
      if (esc_armed) begin
         esc_armed = 1'b0;
         r_a = byte_result(c);
         return 1;
      end
      if (c == CHAR_BSLASH && !sq_open) begin
         esc_armed = 1'b1;
         return 0;
      end
      if (c == CHAR_DQUOTE && !sq_open) begin
         dq_open = !dq_open;
         return 0;
      end
      if (c == CHAR_SQUOTE && !dq_open) begin
         sq_open = !sq_open;
         return 0;
      end
      // unquoted blank closes the argument, even an empty quoted one
      if (is_blank(c) && !sq_open && !dq_open) begin
         r_a = mk_result(KIND_END, '0, args_closed, '0, 1'b1);
         args_closed = args_closed + 1'b1;
         skipping_ws = 1'b1;
         arg_started = 1'b0;
         return 1;
      end
      r_a = byte_result(c);
      return 1;
   endfunction

   function automatic void add_row(input char_type cmd, input logic eos, input logic typed,
                                   input result_type want);
      dir_row_type r;
      r.cmd = cmd;
      r.eos = eos;
      r.typed = typed;
      r.want = want;
      directed_rows.push_back(r);
   endfunction

   function automatic void load_directed_rows();
      // end of string on an empty line; its byte is ignored
      add_row(8'hFF, 1'b1, 1'b1, mk_result(KIND_DONE, '0, '0, '0, 1'b1));
      // leading blanks are skipped
      add_row(CHAR_SPACE, 1'b0, 1'b0, '0);
      add_row(8'h0B, 1'b0, 1'b0, '0);
      // byte extremes
      add_row(8'h00, 1'b0, 1'b1, mk_result(KIND_BYTE, 8'h00, '0, '0, 1'b1));
      add_row(8'hFF, 1'b0, 1'b1, mk_result(KIND_BYTE, 8'hFF, '0, '0, 1'b1));
      add_row(CHAR_TAB, 1'b0, 1'b1, mk_result(KIND_END, '0, '0, '0, 1'b1));
      add_row(8'h0C, 1'b0, 1'b0, '0);
      // empty quoted argument still gets an end mark
      add_row(CHAR_DQUOTE, 1'b0, 1'b0, '0);
      add_row(CHAR_DQUOTE, 1'b0, 1'b0, '0);
      add_row(CHAR_SPACE, 1'b0, 1'b0, '0);
      // double quote and backslash are literal inside single quotes
      add_row(CHAR_SQUOTE, 1'b0, 1'b0, '0);
      add_row(CHAR_DQUOTE, 1'b0, 1'b0, '0);
      add_row(CHAR_BSLASH, 1'b0, 1'b0, '0);
      add_row(CHAR_SQUOTE, 1'b0, 1'b0, '0);
      // single quote literal and escaped double quote inside double quotes
      add_row(CHAR_DQUOTE, 1'b0, 1'b0, '0);
      add_row(CHAR_SQUOTE, 1'b0, 1'b0, '0);
      add_row(CHAR_BSLASH, 1'b0, 1'b0, '0);
      add_row(CHAR_DQUOTE, 1'b0, 1'b0, '0);
      add_row(CHAR_DQUOTE, 1'b0, 1'b0, '0);
      // escaped blank is kept
      add_row(CHAR_BSLASH, 1'b0, 1'b0, '0);
      add_row(CHAR_SPACE, 1'b0, 1'b0, '0);
      // trailing backslash is dropped at end of string
      add_row(CHAR_BSLASH, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b1, 1'b0, '0);
      // open quote at end of string
      add_row(CHAR_SQUOTE, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b1, 1'b1, mk_result(KIND_QUOTE_ERR, '0, '0, '0, 1'b1));
      // empty quoted argument at end of string is not counted
      add_row(CHAR_DQUOTE, 1'b0, 1'b0, '0);
      add_row(CHAR_DQUOTE, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b1, 1'b0, '0);
   endfunction

   function automatic char_type blank_byte();
      if ($urandom_range(0, 2) == 0) return CHAR_SPACE;
      return char_type'($urandom_range(CHAR_TAB, CHAR_CR));
   endfunction

   function automatic char_type plain_byte();
      char_type c;
      do c = char_type'($urandom_range(0, 255));
      while (is_blank(c) || c inside {CHAR_DQUOTE, CHAR_SQUOTE, CHAR_BSLASH});
      return c;
   endfunction

   function automatic char_type any_byte_except(input char_type a, input char_type b);
      char_type c;
      do c = char_type'($urandom_range(0, 255));
      while (c == a || c == b);
      return c;
   endfunction

   function automatic char_type noisy_byte();
      case ($urandom_range(0, 5))
         0: return CHAR_DQUOTE;
         1: return CHAR_SQUOTE;
         2: return CHAR_BSLASH;
         3: return blank_byte();
         default: return char_type'($urandom_range(0, 255));
      endcase
   endfunction

   // Build one command line: mostly well-formed words, sometimes noise.
   function automatic void build_command(input int max_words);
      int words;
      cmd_bytes.delete();
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 12)) cmd_bytes.push_back(noisy_byte());
         return;
      end
      words = $urandom_range(0, max_words);
      repeat ($urandom_range(0, 2)) cmd_bytes.push_back(blank_byte());
      for (int w = 0; w < words; w++) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 5))
               0, 1: repeat ($urandom_range(1, 3)) cmd_bytes.push_back(plain_byte());
               2: begin
                  cmd_bytes.push_back(CHAR_SQUOTE);
                  repeat ($urandom_range(0, 3))
                     cmd_bytes.push_back(any_byte_except(CHAR_SQUOTE, CHAR_SQUOTE));
                  cmd_bytes.push_back(CHAR_SQUOTE);
               end
               3: begin
                  cmd_bytes.push_back(CHAR_DQUOTE);
                  repeat ($urandom_range(0, 3)) begin
                     if ($urandom_range(0, 3) == 0) begin
                        cmd_bytes.push_back(CHAR_BSLASH);
                        cmd_bytes.push_back(char_type'($urandom_range(0, 255)));
                     end else begin
                        cmd_bytes.push_back(any_byte_except(CHAR_DQUOTE, CHAR_BSLASH));
                     end
                  end
                  cmd_bytes.push_back(CHAR_DQUOTE);
               end
               default: begin
                  cmd_bytes.push_back(CHAR_BSLASH);
                  cmd_bytes.push_back(char_type'($urandom_range(0, 255)));
               end
            endcase
         end
         if (w < words - 1 || $urandom_range(0, 1) == 0)
            repeat ($urandom_range(1, 2)) cmd_bytes.push_back(blank_byte());
      end
      if ($urandom_range(0, 11) == 0) cmd_bytes.push_back(CHAR_BSLASH);
   endfunction

   // Offer one item in bursts, with gaps between bursts when sender_gaps_on is set; predict once it is taken.
   task automatic send_item(input char_type cmd, input logic eos, input logic typed,
                            input result_type want);
      int gap;
      int n;
      result_type r_a;
      result_type r_b;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if (sender_gaps_on) gap = $urandom_range(1, 5);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd_byte <= cmd;
      req_end_of_string <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      counted_items++;
      n = split_step(cmd, eos, r_a, r_b);
      if (typed) begin
         expected_results.push_back(want);
      end else begin
         if (n > 0) expected_results.push_back(r_a);
         if (n > 1) expected_results.push_back(r_b);
      end
   endtask

   task automatic write_max_args(input count_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_max_args <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      arg_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop sending, wait for all results, then let the pipeline go quiet.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endfunction

   // Receiver stall pattern: a rotating 16-bit ready mask that is reloaded at random
   always @(negedge clock) begin
      ready_tick++;
      if (ready_tick % 40 == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pattern = 16'hFFFF;
            1: ready_pattern = 16'($urandom);
            2: ready_pattern = 16'($urandom | $urandom);
            default: ready_pattern = 16'($urandom & $urandom);
         endcase
         if (ready_pattern == '0) ready_pattern = 16'h0001;
      end
      rsp_ready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
   end

   // Result checker
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = mk_result(rsp_kind, rsp_out_byte, rsp_arg_index, rsp_arg_count, rsp_last);
         if (expected_results.size() == 0) begin
            note_fault($sformatf("unexpected result: kind %0d byte %02h arg %0d count %0d last %0d",
                                 got.kind, got.out_byte, got.arg_index, got.arg_count,
                                 got.last));
         end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                got.arg_index !== want.arg_index || got.arg_count !== want.arg_count ||
                got.last !== want.last)
               note_fault($sformatf({"result mismatch: expected kind %0d byte %02h arg %0d ",
                                     "count %0d last %0d, got kind %0d byte %02h arg %0d ",
                                     "count %0d last %0d"},
                                    want.kind, want.out_byte, want.arg_index,
                                    want.arg_count, want.last, got.kind, got.out_byte,
                                    got.arg_index, got.arg_count, got.last));
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("quoted_argument_splitter_unit_tb NOT OK");
         $finish;
      end
   end

   // Stimulus: directed rows, then random command lines over several limits, then a run past the limit
   initial begin
      count_type new_limit;
      int quota;
      int max_words;
      arg_limit = MaxArgsReset;
      clear_split_state();
      load_directed_rows();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NumPhases; ph++) begin
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         counted_items = 0;
         case (ph)
            0: new_limit = MaxArgsReset;
            1: new_limit = 8'd1;
            2: new_limit = 8'd2;
            3: new_limit = 8'd3;
            4: new_limit = 8'd0;
            6: new_limit = count_type'($urandom_range(4, 254));
            7: new_limit = count_type'($urandom_range(20, 40));
            default: new_limit = MaxArgsReset;
         endcase
         if (ph > 0) begin
            settle();
            write_max_args(new_limit);
         end
         quota = (new_limit == 0) ? 30 : PhaseQuota;
         max_words = (new_limit < 4) ? 5 : 7;

         if (ph == 0)
            foreach (directed_rows[i])
               send_item(directed_rows[i].cmd, directed_rows[i].eos, directed_rows[i].typed,
                         directed_rows[i].want);

         if (ph == NumPhases - 1) begin
            // fill every argument slot and run past the limit
            for (int a = 0; a < int'(new_limit) + 3; a++) begin
               send_item(plain_byte(), 1'b0, 1'b0, '0);
               send_item(blank_byte(), 1'b0, 1'b0, '0);
            end
            send_item(char_type'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
         end else begin
            while (counted_items < quota) begin
               build_command(max_words);
               foreach (cmd_bytes[i]) send_item(cmd_bytes[i], 1'b0, 1'b0, '0);
               send_item(char_type'($urandom_range(0, 255)), ($urandom_range(0, 9) != 0),
                         1'b0, '0);
            end
         end
      end

      settle();
      if (fault_count == 0) begin
         $display("quoted_argument_splitter_unit_tb OK");
      end else begin
         $display("quoted_argument_splitter_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
